// ----- rtl/nearest_note_and_cents_top_defines.svh -----
// Assertion macros for the nearest note and cents block.
`ifndef NEAREST_NOTE_AND_CENTS_TOP_DEFINES_SVH
`define NEAREST_NOTE_AND_CENTS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define NNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define NNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/nnc_pkg.sv -----
package nnc_pkg;

    localparam int KEY_COUNT_DEF       = 88;
    localparam int FIRST_MIDI_NOTE_DEF = 21;

    localparam int FREQ_W   = 16;
    localparam int KEY_W    = 7;
    localparam int PC_W     = 4;
    localparam int OCT_W    = 4;
    localparam int EXP_W    = 13;
    localparam int CENTS_W  = 8;
    localparam int HZ_W     = 14;
    localparam int MIDI_W   = 7;
    localparam int X_W      = 31;
    localparam int FRAC_W   = 24;
    localparam int DIGIT_W  = 8;
    localparam int MPY_W    = 32;
    localparam int ACC_W    = 62;
    localparam int MAG_W    = 11;
    localparam int CNT_SEQ_W = 5;

    localparam logic [CNT_SEQ_W-1:0] DIV_LAST_CNT = 5'd29;
    localparam logic [CNT_SEQ_W-1:0] SQR_LAST_CNT = 5'd23;
    localparam logic [1:0]           DIGIT_LAST   = 2'd3;
    localparam logic [MAG_W-1:0]     CENTS_SCALE  = 11'd1200;
    localparam logic [7:0]           RECIP_12     = 8'd171;
    localparam int                   RECIP_SHIFT  = 11;

    localparam logic [HZ_W-1:0] MIDI_HZ [128] = '{
        8, 8, 9, 9, 10, 10, 11, 12, 12, 13, 14, 15,
        16, 17, 18, 19, 20, 21, 23, 24, 25, 27, 29, 30,
        32, 34, 36, 38, 41, 43, 46, 48, 51, 55, 58, 61,
        65, 69, 73, 77, 82, 87, 92, 97, 103, 110, 116, 123,
        130, 138, 146, 155, 164, 174, 184, 195, 207, 220, 233, 246,
        261, 277, 293, 311, 329, 349, 369, 391, 415, 440, 466, 493,
        523, 554, 587, 622, 659, 698, 739, 783, 830, 880, 932, 987,
        1046, 1108, 1174, 1244, 1318, 1396, 1479, 1567, 1661, 1760, 1864, 1975,
        2093, 2217, 2349, 2489, 2637, 2793, 2959, 3135, 3322, 3520, 3729, 3951,
        4186, 4434, 4698, 4978, 5274, 5587, 5919, 6271, 6644, 7040, 7458, 7902,
        8372, 8869, 9397, 9956, 10548, 11175, 11839, 12543
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PICK,
        ST_PREP,
        ST_DIV,
        ST_SQR,
        ST_SCALE,
        ST_DONE
    } t_state;

    // Keys past the top of the MIDI range stay on the top note.
    function automatic logic [MIDI_W-1:0] key_midi(input logic [7:0] idx,
                                                   input logic [MIDI_W-1:0] first);
        logic [8:0] m;
        m = 9'(idx) + 9'(first);
        return (m > 9'd127) ? 7'd127 : m[MIDI_W-1:0];
    endfunction

    function automatic logic [HZ_W-1:0] key_hz(input logic [7:0] idx,
                                               input logic [MIDI_W-1:0] first);
        return MIDI_HZ[key_midi(idx, first)];
    endfunction

endpackage

// ----- rtl/nnc_in_if.sv -----
interface nnc_in_if
    import nnc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency_hz;

    modport source (output valid, output frequency_hz, input ready);
    modport sink   (input valid, input frequency_hz, output ready);
endinterface

// ----- rtl/nnc_out_if.sv -----
interface nnc_out_if
    import nnc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [KEY_W-1:0]          key_index;
    logic [PC_W-1:0]           pitch_class;
    logic [OCT_W-1:0]          octave_number;
    logic [EXP_W-1:0]          expected_hz;
    logic signed [CENTS_W-1:0] cents_off;

    modport source (output valid, output found, output key_index, output pitch_class,
                    output octave_number, output expected_hz, output cents_off,
                    input ready);
    modport sink   (input valid, input found, input key_index, input pitch_class,
                    input octave_number, input expected_hz, input cents_off,
                    output ready);
endinterface

// ----- rtl/nearest_note_and_cents_top.sv -----
// Channel   Dir  Payload
// i_in      in   frequency_hz
// o_out     out  found, key_index, pitch_class, octave_number, expected_hz, cents_off
//
// One item is worked on at a time: a new one is taken only once the last has reached the output register.
// Every item goes through a bit-serial search; a found one then through the 30-step restoring divider
// and the 24 squarings of the log, each four 8-bit digit passes of one multiplier.
// A saturated deviation skips the divider and the squarings.
// Reset is synchronous; a finished item waits in the output register while a new one is taken.
`include "nearest_note_and_cents_top_defines.svh"

module nearest_note_and_cents_top
    import nnc_pkg::*;
#(
    parameter int KEY_COUNT       = KEY_COUNT_DEF,
    parameter int FIRST_MIDI_NOTE = FIRST_MIDI_NOTE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nnc_in_if.sink        i_in,
    nnc_out_if.source     o_out
);

    localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int CNT_W = $clog2(KEY_COUNT + 1);
    localparam int BIT_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;
    localparam logic [MIDI_W-1:0] FIRST_M   = MIDI_W'(FIRST_MIDI_NOTE);
    localparam logic [CNT_W:0]    KEY_LIM   = (CNT_W + 1)'(KEY_COUNT);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(KEY_COUNT - 1);
    localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(CNT_W - 1);

    t_state                    r_state, n_state;
    logic [FREQ_W-1:0]         r_f, n_f;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [BIT_W-1:0]          r_bit, n_bit;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [HZ_W-1:0]           r_e, n_e;
    logic                      r_found, n_found;
    logic [PC_W-1:0]           r_pc, n_pc;
    logic [OCT_W-1:0]          r_oct, n_oct;
    logic                      r_neg, n_neg;
    logic                      r_sat, n_sat;
    logic [FREQ_W-1:0]         r_rem, n_rem;
    logic [FREQ_W-1:0]         r_b, n_b;
    logic [X_W-1:0]            r_x, n_x;
    logic [MPY_W-1:0]          r_mpy, n_mpy;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic [1:0]                r_dig, n_dig;
    logic [CNT_SEQ_W-1:0]      r_cnt, n_cnt;
    logic [FRAC_W-1:0]         r_frac, n_frac;
    logic signed [CENTS_W-1:0] r_cents, n_cents;
    logic                      r_o_valid, n_o_valid;
    logic                      r_o_found;
    logic [KEY_W-1:0]          r_o_key;
    logic [PC_W-1:0]           r_o_pc;
    logic [OCT_W-1:0]          r_o_oct;
    logic [EXP_W-1:0]          r_o_exp;
    logic signed [CENTS_W-1:0] r_o_cents;
    logic                      w_load_out;

    logic [CNT_W:0]            w_probe;
    logic [IDX_W-1:0]          w_up;
    logic [HZ_W-1:0]           w_hi, w_lo;
    logic [FREQ_W-1:0]         w_dh, w_dl, w_e16, w_a, w_b;
    logic [MIDI_W-1:0]         w_m;
    logic [14:0]               w_q_prod;
    logic [3:0]                w_q;
    logic [FREQ_W:0]           w_r2;
    logic                      w_ge;
    logic [38:0]               w_dprod;
    logic [ACC_W-1:0]          w_acc;
    logic [31:0]               w_y;
    logic [34:0]               w_sprod;
    logic [MAG_W-1:0]          w_mag;

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.found         = r_o_found;
    assign o_out.key_index     = r_o_key;
    assign o_out.pitch_class   = r_o_pc;
    assign o_out.octave_number = r_o_oct;
    assign o_out.expected_hz   = r_o_exp;
    assign o_out.cents_off     = r_o_cents;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f     <= n_f;
        r_pos   <= n_pos;
        r_bit   <= n_bit;
        r_idx   <= n_idx;
        r_e     <= n_e;
        r_found <= n_found;
        r_pc    <= n_pc;
        r_oct   <= n_oct;
        r_neg   <= n_neg;
        r_sat   <= n_sat;
        r_rem   <= n_rem;
        r_b     <= n_b;
        r_x     <= n_x;
        r_mpy   <= n_mpy;
        r_acc   <= n_acc;
        r_dig   <= n_dig;
        r_cnt   <= n_cnt;
        r_frac  <= n_frac;
        r_cents <= n_cents;
        if (w_load_out) begin
            r_o_found <= r_found;
            r_o_key   <= KEY_W'(r_idx);
            r_o_pc    <= r_pc;
            r_o_oct   <= r_oct;
            r_o_exp   <= r_e[EXP_W-1:0];
            r_o_cents <= r_cents;
        end
    end

    always_comb begin
        w_probe  = (CNT_W + 1)'(r_pos) + ((CNT_W + 1)'(1) << r_bit);
        w_up     = (r_pos >= CNT_W'(KEY_COUNT - 1)) ? LAST_IDX :
                   (r_pos == '0) ? IDX_W'(1) : r_pos[IDX_W-1:0];
        w_hi     = key_hz(8'(w_up), FIRST_M);
        w_lo     = key_hz(8'(w_up - IDX_W'(1)), FIRST_M);
        w_dh     = (FREQ_W'(w_hi) > r_f) ? FREQ_W'(w_hi) - r_f : r_f - FREQ_W'(w_hi);
        w_dl     = (FREQ_W'(w_lo) > r_f) ? FREQ_W'(w_lo) - r_f : r_f - FREQ_W'(w_lo);
        w_e16    = FREQ_W'(r_e);
        w_a      = (r_f < w_e16) ? w_e16 : r_f;
        w_b      = (r_f < w_e16) ? r_f : w_e16;
        w_m      = key_midi(8'(r_idx), FIRST_M);
        w_q_prod = 15'(w_m) * 15'(RECIP_12);
        w_q      = 4'(w_q_prod >> RECIP_SHIFT);
        w_r2     = {r_rem, 1'b0};
        w_ge     = (w_r2 >= {1'b0, r_b});
        w_dprod  = 39'(r_x) * 39'(r_mpy[MPY_W-1 -: DIGIT_W]);
        w_acc    = (r_acc << DIGIT_W) + ACC_W'(w_dprod);
        w_y      = w_acc[ACC_W-1:30];
        w_sprod  = 35'(r_frac) * 35'(CENTS_SCALE);
        w_mag    = w_sprod[34:FRAC_W];
    end

    always_comb begin
        n_state    = r_state;
        n_f        = r_f;
        n_pos      = r_pos;
        n_bit      = r_bit;
        n_idx      = r_idx;
        n_e        = r_e;
        n_found    = r_found;
        n_pc       = r_pc;
        n_oct      = r_oct;
        n_neg      = r_neg;
        n_sat      = r_sat;
        n_rem      = r_rem;
        n_b        = r_b;
        n_x        = r_x;
        n_mpy      = r_mpy;
        n_acc      = r_acc;
        n_dig      = r_dig;
        n_cnt      = r_cnt;
        n_frac     = r_frac;
        n_cents    = r_cents;
        w_load_out = 1'b0;
        n_o_valid  = r_o_valid && !o_out.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_f     = i_in.frequency_hz;
                    n_pos   = '0;
                    n_bit   = TOP_BIT;
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Count of keys at or below the input, one bit of the count per cycle.
                if (w_probe <= KEY_LIM &&
                    FREQ_W'(key_hz(8'(w_probe - (CNT_W + 1)'(1)), FIRST_M)) <= r_f) begin
                    n_pos = w_probe[CNT_W-1:0];
                end
                if (r_bit == '0) begin
                    n_state = ST_PICK;
                end else begin
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            ST_PICK: begin
                if (r_f < FREQ_W'(key_hz(8'd0, FIRST_M))) begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_e     = '0;
                    n_pc    = '0;
                    n_oct   = '0;
                    n_cents = '0;
                    n_state = ST_DONE;
                end else begin
                    n_found = 1'b1;
                    n_idx   = (w_dh < w_dl) ? w_up : w_up - IDX_W'(1);
                    n_e     = (w_dh < w_dl) ? w_hi : w_lo;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_pc    = 4'(w_m - 7'(w_q) * 7'd12);
                n_oct   = w_q - 4'd1;
                n_neg   = (r_f < w_e16);
                n_sat   = ({1'b0, w_a} >= {w_b, 1'b0});
                n_rem   = w_a - w_b;
                n_b     = w_b;
                n_x     = X_W'(1);
                n_cnt   = DIV_LAST_CNT;
                n_state = n_sat ? ST_SCALE : ST_DIV;
            end
            ST_DIV: begin
                n_rem = w_ge ? FREQ_W'(w_r2 - {1'b0, r_b}) : w_r2[FREQ_W-1:0];
                n_x   = {r_x[X_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_mpy   = {1'b0, n_x};
                    n_acc   = '0;
                    n_dig   = '0;
                    n_frac  = '0;
                    n_cnt   = SQR_LAST_CNT;
                    n_state = ST_SQR;
                end else begin
                    n_cnt = r_cnt - CNT_SEQ_W'(1);
                end
            end
            ST_SQR: begin
                if (r_dig == DIGIT_LAST) begin
                    // Square is complete: take one bit of the log and renormalize.
                    n_x    = w_y[31] ? w_y[31:1] : w_y[X_W-1:0];
                    n_frac = {r_frac[FRAC_W-2:0], w_y[31]};
                    n_mpy  = {1'b0, n_x};
                    n_acc  = '0;
                    n_dig  = '0;
                    if (r_cnt == '0) begin
                        n_state = ST_SCALE;
                    end else begin
                        n_cnt = r_cnt - CNT_SEQ_W'(1);
                    end
                end else begin
                    n_acc = w_acc;
                    n_mpy = r_mpy << DIGIT_W;
                    n_dig = r_dig + 2'd1;
                end
            end
            ST_SCALE: begin
                if (r_neg) begin
                    n_cents = (r_sat || w_mag > MAG_W'(128)) ? -8'sd128 :
                              $signed(8'(~w_mag[7:0] + 8'd1));
                end else begin
                    n_cents = (r_sat || w_mag > MAG_W'(127)) ? 8'sd127 : $signed(w_mag[7:0]);
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_o_valid  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `NNC_ASSERT_NEXT(a_accept_starts_search, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == ST_SEARCH, "accepted item did not start the search")
    `NNC_ASSERT_NOW(a_div_rem_below_divisor, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_b, "divider remainder not below divisor")
    `NNC_ASSERT_NOW(a_sqr_normalized, i_clk, i_rst_n, r_state == ST_SQR, r_x[X_W-1], "log operand left its normalized range")
    `NNC_ASSERT_NOW(a_not_found_zero, i_clk, i_rst_n, o_out.valid && !o_out.found, o_out.key_index == '0 && o_out.expected_hz == '0 && o_out.cents_off == '0, "not found result carries data")
    `NNC_ASSERT_NOW(a_pitch_class_range, i_clk, i_rst_n, o_out.valid && o_out.found, o_out.pitch_class < 4'd12, "pitch class out of range")

endmodule

// ----- sim/tb_nearest_note_and_cents_top.sv -----
module tb_nearest_note_and_cents_top
    import nnc_pkg::*;
;
    localparam int KEYS           = KEY_COUNT_DEF;
    localparam int FIRST_MIDI     = FIRST_MIDI_NOTE_DEF;
    localparam int RANDOM_ITEMS   = 500;
    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_AT        = 100;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES    = 300;

    localparam logic [FREQ_W-1:0] DIRECTED [24] = '{
        16'd0, 16'd1, 16'd26, 16'd27, 16'd28, 16'd29, 16'd31, 16'd32,
        16'd440, 16'd446, 16'd453, 16'd1000, 16'd2000, 16'd3951, 16'd4000, 16'd4186,
        16'd4187, 16'd4400, 16'd8191, 16'd8192, 16'h5555, 16'hAAAA, 16'd32768, 16'd65535
    };

    typedef struct packed {
        logic                      found;
        logic [KEY_W-1:0]          key_index;
        logic [PC_W-1:0]           pitch_class;
        logic [OCT_W-1:0]          octave_number;
        logic [EXP_W-1:0]          expected_hz;
        logic signed [CENTS_W-1:0] cents_off;
    } note_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nnc_in_if  in_ch ();
    nnc_out_if out_ch ();

    nearest_note_and_cents_top #(
        .KEY_COUNT       (KEYS),
        .FIRST_MIDI_NOTE (FIRST_MIDI)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [HZ_W-1:0]   key_hz_tab [KEYS];
    logic [FREQ_W-1:0] freq_backlog [$];
    note_t             pending_notes [$];
    note_t             head_note;
    int                mismatches = 0;
    int unsigned       rx_count;
    int unsigned       rx_stall;
    int unsigned       rx_draw;
    int unsigned       tx_gap;
    logic              hold_done;
    logic              calm;

    function automatic int unsigned key_midi_of(input int unsigned idx);
        return (FIRST_MIDI + idx > 127) ? 127 : FIRST_MIDI + idx;
    endfunction

    // Magnitude of 1200*log2(a/b) by repeated squaring in Q30, 1000 when a >= 2b.
    function automatic int unsigned log_cents_mag(input int unsigned a, input int unsigned b);
        logic [63:0] x;
        logic [23:0] frac;
        int          step;
        if (b == 0 || a >= 2 * b) return 1000;
        x = (64'(a) << 30) / 64'(b);
        frac = '0;
        for (step = 0; step < 24; step++) begin
            x = (x * x) >> 30;
            frac = {frac[22:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                frac[0] = 1'b1;
                x = x >> 1;
            end
        end
        return 32'((64'(frac) * 64'd1200) >> 24);
    endfunction

    function automatic note_t predict_note(input logic [FREQ_W-1:0] freq);
        note_t       r;
        int unsigned f, k, above, idx, e, m, mag, dhi, dlo;
        int          cents;
        r = '0;
        f = freq;
        if (f < key_hz_tab[0]) return r;
        above = 0;
        for (k = 0; k < KEYS; k++) begin
            if (key_hz_tab[k] <= f) above++;
        end
        if (above >= KEYS) above = KEYS - 1;
        if (above == 0) above = 1;
        dhi = (key_hz_tab[above] > f) ? key_hz_tab[above] - f : f - key_hz_tab[above];
        dlo = (key_hz_tab[above-1] > f) ? key_hz_tab[above-1] - f : f - key_hz_tab[above-1];
        idx = (dhi < dlo) ? above : above - 1;
        e = key_hz_tab[idx];
        m = key_midi_of(idx);
        if (f >= e) begin
            mag = log_cents_mag(f, e);
            cents = (mag > 127) ? 127 : int'(mag);
        end else begin
            mag = log_cents_mag(e, f);
            cents = (mag > 128) ? -128 : -int'(mag);
        end
        r.found         = 1'b1;
        r.key_index     = KEY_W'(idx);
        r.pitch_class   = PC_W'(m % 12);
        r.octave_number = OCT_W'(m / 12 - 1);
        r.expected_hz   = EXP_W'(e);
        r.cents_off     = CENTS_W'(cents);
        return r;
    endfunction

    function automatic int unsigned rand_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 200);
    endfunction

    function automatic logic [FREQ_W-1:0] rand_freq();
        int unsigned pick, k, f;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, KEYS - 2);
        if (pick < 10) begin
            f = $urandom_range(0, key_hz_tab[0] - 1);
        end else if (pick < 55) begin
            f = $urandom_range(key_hz_tab[0], key_hz_tab[KEYS-1]);
        end else if (pick < 80) begin
            f = key_hz_tab[k] + $urandom_range(0, 6) - 3;
        end else if (pick < 90) begin
            f = (key_hz_tab[k] + key_hz_tab[k+1]) / 2 + $urandom_range(0, 1);
        end else begin
            f = $urandom_range(0, 65535);
        end
        return f[FREQ_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("result %0d: %s", rx_count, what);
        mismatches++;
    endtask

    task automatic wait_drained();
        while (freq_backlog.size() != 0 || in_ch.valid || pending_notes.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.frequency_hz <= '0;
            tx_gap <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) pending_notes.push_back(predict_note(in_ch.frequency_hz));
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (freq_backlog.size() != 0) begin
                in_ch.valid <= 1'b1;
                in_ch.frequency_hz <= freq_backlog.pop_front();
                tx_gap <= rand_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_stall <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && rx_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            rx_stall <= RX_HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall <= rx_stall - 1;
            out_ch.ready <= 1'b0;
        end else begin
            rx_draw = ($urandom_range(0, 9) == 0) ? rand_gap() : 0;
            rx_stall <= (rx_draw == 0) ? 0 : rx_draw - 1;
            out_ch.ready <= (rx_draw == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_count <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            rx_count <= rx_count + 1;
            if (pending_notes.size() == 0) begin
                report_mismatch("result arrived with no item pending");
            end else begin
                head_note = pending_notes.pop_front();
                if (out_ch.found !== head_note.found)
                    report_mismatch($sformatf("found is %0d, predicted %0d",
                                              out_ch.found, head_note.found));
                if (out_ch.key_index !== head_note.key_index)
                    report_mismatch($sformatf("key_index is %0d, predicted %0d",
                                              out_ch.key_index, head_note.key_index));
                if (out_ch.pitch_class !== head_note.pitch_class)
                    report_mismatch($sformatf("pitch_class is %0d, predicted %0d",
                                              out_ch.pitch_class, head_note.pitch_class));
                if (out_ch.octave_number !== head_note.octave_number)
                    report_mismatch($sformatf("octave_number is %0d, predicted %0d",
                                              out_ch.octave_number, head_note.octave_number));
                if (out_ch.expected_hz !== head_note.expected_hz)
                    report_mismatch($sformatf("expected_hz is %0d, predicted %0d",
                                              out_ch.expected_hz, head_note.expected_hz));
                if (out_ch.cents_off !== head_note.cents_off)
                    report_mismatch($sformatf("cents_off is %0d, predicted %0d",
                                              out_ch.cents_off, head_note.cents_off));
            end
        end
    end

    initial begin
        int unsigned k;
        i_rst_n = 1'b0;
        calm = 1'b0;
        for (k = 0; k < KEYS; k++) key_hz_tab[k] = MIDI_HZ[key_midi_of(k)];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[n]) freq_backlog.push_back(DIRECTED[n]);
        wait_drained();

        calm <= 1'b1;
        repeat (CALM_ITEMS) freq_backlog.push_back(rand_freq());
        while (freq_backlog.size() != 0) @(posedge i_clk);
        calm <= 1'b0;
        repeat (RANDOM_ITEMS - CALM_ITEMS) freq_backlog.push_back(rand_freq());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("nearest_note_and_cents_top: match");
        end else begin
            $display("nearest_note_and_cents_top: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("nearest_note_and_cents_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nnc_pkg.sv
rtl/nnc_in_if.sv
rtl/nnc_out_if.sv
rtl/nearest_note_and_cents_top.sv
sim/tb_nearest_note_and_cents_top.sv
